FILE: rtl/hcm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hcm_pkg;

  // Key matrix geometry.
  localparam int MAX_BLOCK  = 8;
  localparam int IDX_W      = 3;
  localparam int KEY_DEPTH  = MAX_BLOCK * MAX_BLOCK;
  localparam int KEY_ADDR_W = 2 * IDX_W;

  // Symbol and arithmetic widths.
  localparam int SYM_W  = 6;
  localparam int FILL_W = 4;
  localparam int CFG_W  = 4;
  localparam int PROD_W = 2 * SYM_W;
  localparam int ACC_W  = 15;
  localparam int Q_W    = 9;

  // Reduction mod 37 by reciprocal: q = (acc * RECIP_M) >> RECIP_SH is exact for acc < 2^15.
  localparam int RECIP_W  = 16;
  localparam logic [RECIP_W-1:0] RECIP_M = 16'd56680;
  localparam int RECIP_SH = 21;

  localparam logic [SYM_W-1:0] SYM_SPACE = 6'd36;

  // Word layout.
  localparam int IN_W  = 24;
  localparam int OUT_W = 8;

  // Opcodes.
  localparam logic [1:0] OP_KEY   = 2'd0;
  localparam logic [1:0] OP_CHAR  = 2'd1;
  localparam logic [1:0] OP_FLUSH = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             key_we;
    logic             buf_we;
    logic [IDX_W-1:0] buf_idx;
    logic             acc_clr;
    logic             rd;
    logic [IDX_W-1:0] rd_row;
    logic [IDX_W-1:0] rd_col;
    logic             pad;
    logic             quo_en;
    logic             out_load;
    logic             out_last;
  } cmd_t;

endpackage

`default_nettype wire

FILE: rtl/hcm_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module hcm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/hcm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module hcm_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic [hcm_pkg::CFG_W-1:0] cfg_wdata,
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  input  wire logic [1:0]                in_opcode,
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  output hcm_pkg::cmd_t                  cmd
);
  import hcm_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MAC   = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_QUO   = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  localparam logic [CFG_W-1:0]  MAX_N = CFG_W'(MAX_BLOCK);

  logic [2:0]        state_r, state_nxt;
  logic [CFG_W-1:0]  bsize_r, bsize_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [IDX_W-1:0]  row_r, row_nxt;
  logic [IDX_W-1:0]  col_r, col_nxt;
  logic              oval_r, oval_nxt;

  logic [FILL_W-1:0] n_eff;
  logic [FILL_W-1:0] n_m1;
  logic [FILL_W-1:0] pos;
  logic              out_free;
  logic              last_row;

  always_comb begin
    if (bsize_r == '0) begin
      n_eff = FILL_W'(1);
    end else if (bsize_r > MAX_N) begin
      n_eff = FILL_W'(MAX_BLOCK);
    end else begin
      n_eff = FILL_W'(bsize_r);
    end
  end

  assign n_m1     = n_eff - FILL_W'(1);
  assign pos      = (fill_r >= n_eff) ? n_m1 : fill_r;
  assign out_free = !oval_r || out_tready;
  assign last_row = {1'b0, row_r} == n_m1;

  assign in_tready  = state_r == S_IDLE;
  assign out_tvalid = oval_r;
  assign bsize_nxt  = cfg_we ? cfg_wdata : bsize_r;

  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    cmd       = '0;
    cmd.rd_row = row_r;
    cmd.rd_col = col_r;
    cmd.buf_idx = pos[IDX_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          unique case (in_opcode)
            OP_KEY: begin
              cmd.key_we = 1'b1;
            end
            OP_CHAR: begin
              cmd.buf_we = 1'b1;
              fill_nxt   = pos + FILL_W'(1);
              if (pos == n_m1) begin
                row_nxt     = '0;
                col_nxt     = '0;
                cmd.acc_clr = 1'b1;
                state_nxt   = S_MAC;
              end
            end
            OP_FLUSH: begin
              if (fill_r != '0) begin
                row_nxt     = '0;
                col_nxt     = '0;
                cmd.acc_clr = 1'b1;
                state_nxt   = S_MAC;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_MAC: begin
        cmd.rd  = 1'b1;
        // Slots at or past the fill count are padding and read as space.
        cmd.pad = {1'b0, col_r} >= fill_r;
        if ({1'b0, col_r} == n_m1) begin
          state_nxt = S_DRAIN;
        end else begin
          col_nxt = col_r + IDX_W'(1);
        end
      end
      S_DRAIN: begin
        state_nxt = S_QUO;
      end
      S_QUO: begin
        cmd.quo_en = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = last_row;
          cmd.acc_clr  = 1'b1;
          if (last_row) begin
            fill_nxt  = '0;
            state_nxt = S_IDLE;
          end else begin
            row_nxt   = row_r + IDX_W'(1);
            col_nxt   = '0;
            state_nxt = S_MAC;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      oval_nxt = 1'b1;
    end else if (out_tready) begin
      oval_nxt = 1'b0;
    end else begin
      oval_nxt = oval_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      bsize_r <= CFG_W'(1);
      fill_r  <= '0;
      row_r   <= '0;
      col_r   <= '0;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      bsize_r <= bsize_nxt;
      fill_r  <= fill_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      oval_r  <= oval_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/hcm_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module hcm_dp (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic [hcm_pkg::IN_W-1:0] in_tdata,
  input  hcm_pkg::cmd_t                 cmd,
  output logic [hcm_pkg::OUT_W-1:0]     out_char,
  output logic                          out_last
);
  import hcm_pkg::*;

  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_Z     = 8'h5A;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [SYM_W-1:0] SYM_DIGIT0 = 6'd26;
  localparam logic [SYM_W-1:0] SYM_LAST_LETTER = 6'd25;
  localparam logic [SYM_W-1:0] SYM_LAST_DIGIT  = 6'd35;
  localparam logic [Q_W:0]     ALPHA_MOD = 10'd37;

  function automatic logic [SYM_W-1:0] sym_of_char(input logic [7:0] c);
    logic [SYM_W-1:0] s;
    if (c >= CH_A && c <= CH_Z) begin
      s = SYM_W'(c - CH_A);
    end else if (c >= CH_0 && c <= CH_9) begin
      s = SYM_W'(c - CH_0) + SYM_DIGIT0;
    end else begin
      s = SYM_SPACE;
    end
    return s;
  endfunction

  function automatic logic [7:0] char_of_sym(input logic [SYM_W-1:0] s);
    logic [7:0] c;
    if (s <= SYM_LAST_LETTER) begin
      c = 8'(s) + CH_A;
    end else if (s <= SYM_LAST_DIGIT) begin
      c = 8'(s - SYM_DIGIT0) + CH_0;
    end else begin
      c = CH_SPACE;
    end
    return c;
  endfunction

  logic [1:0]        f_op;
  logic [IDX_W-1:0]  f_row;
  logic [IDX_W-1:0]  f_col;
  logic [SYM_W-1:0]  f_kval;
  logic [7:0]        f_char;

  assign f_op   = in_tdata[1:0];
  assign f_row  = in_tdata[4:2];
  assign f_col  = in_tdata[7:5];
  assign f_kval = in_tdata[13:8];
  assign f_char = in_tdata[21:14];

  logic [SYM_W-1:0]   buf_r [MAX_BLOCK];
  logic [SYM_W-1:0]   key_rd;
  logic [SYM_W-1:0]   sym_d_r;
  logic               rd_d_r;
  logic [ACC_W-1:0]   acc_r;
  logic [Q_W-1:0]     q_r;
  logic [PROD_W-1:0]  prod;
  logic [ACC_W+RECIP_W-1:0] q_full;
  logic [ACC_W:0]     qm;
  logic [ACC_W:0]     rem;
  logic [OUT_W-1:0]   char_r;
  logic               last_r;

  hcm_ram #(
    .WIDTH (SYM_W),
    .DEPTH (KEY_DEPTH)
  ) u_key_ram (
    .clk   (clk),
    .we    (cmd.key_we),
    .waddr ({f_row, f_col}),
    .wdata (f_kval),
    .raddr ({cmd.rd_row, cmd.rd_col}),
    .rdata (key_rd)
  );

  assign prod   = key_rd * sym_d_r;
  assign q_full = acc_r * RECIP_M;
  // q * 37 by shifts and adds.
  assign qm     = ((ACC_W+1)'(q_r) << 5) + ((ACC_W+1)'(q_r) << 2) + (ACC_W+1)'(q_r);
  assign rem    = {1'b0, acc_r} - qm;

  always_ff @(posedge clk) begin
    if (cmd.buf_we) begin
      buf_r[cmd.buf_idx] <= sym_of_char(f_char);
    end
    sym_d_r <= cmd.pad ? SYM_SPACE : buf_r[cmd.rd_col];
    if (cmd.acc_clr) begin
      acc_r <= '0;
    end else if (rd_d_r) begin
      acc_r <= acc_r + ACC_W'(prod);
    end
    if (cmd.quo_en) begin
      q_r <= q_full[RECIP_SH +: Q_W];
    end
    if (cmd.out_load) begin
      char_r <= char_of_sym(rem[SYM_W-1:0]);
      last_r <= cmd.out_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_d_r <= 1'b0;
    end else begin
      rd_d_r <= cmd.rd;
    end
  end

  assign out_char = char_r;
  assign out_last = last_r;

  // Opcode bits are decoded in the controller; the modulus constant and the top word bits are unused here.
  logic unused_ok;
  assign unused_ok = ^{f_op, ALPHA_MOD, in_tdata[IN_W-1:22]};

endmodule

`default_nettype wire

FILE: rtl/hill_cipher_mod37_stream.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Ports                        Contents
// in        in   in_tvalid/in_tready/in_tdata  opcode, key entry or plaintext character
// out       out  out_tvalid/out_tready/...     cipher character, tlast on block end
// cfg       in   cfg_we/cfg_wdata              block_size register
//
// A key write or a character that does not complete a block leaves the controller idle.
// A block of n symbols is emitted one row at a time: multiply-accumulate
// through the key RAM read port over the row, then drain, reciprocal
// quotient, and remainder with output load to finish the row.
// The input is taken only while the controller is idle; a full output
// register stalls the row finish until the word is taken.
// Reset clears the controller and sets block_size to 1; key entries and
// buffered symbols are undefined until written.

module hill_cipher_mod37_stream (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic [hcm_pkg::CFG_W-1:0] cfg_wdata,     // block_size
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  // [1:0] opcode, [4:2] key_row, [7:5] key_col, [13:8] key_value,
  // [21:14] char_code, [23:22] zero
  input  wire logic [hcm_pkg::IN_W-1:0]  in_tdata,
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  output logic [hcm_pkg::OUT_W-1:0]      out_tdata,     // [7:0] cipher_char
  output logic                           out_tlast      // last
);
  import hcm_pkg::*;

  cmd_t cmd;

  hcm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_opcode  (in_tdata[1:0]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  // The datapath holds the key RAM, the block buffer, the accumulator
  // and the output word register.
  hcm_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tdata (in_tdata),
    .cmd      (cmd),
    .out_char (out_tdata),
    .out_last (out_tlast)
  );

endmodule

`default_nettype wire
